// ----- src/abs_pkg.sv -----
// abs_pkg: shared types, widths, op codes and helpers for the adaptive bitrate selector
// no dependencies; imported by every module under src
package abs_pkg;

  localparam int unsigned OPT_W   = 20;
  localparam int unsigned RATE_W  = 40;
  localparam int unsigned BYTES_W = 32;
  localparam int unsigned DUR_W   = 16;
  localparam int unsigned WGT_W   = 17;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned DIVD_W  = BYTES_W + FRAC_W;
  localparam int unsigned PROD_W  = WGT_W + OPT_W;
  localparam int unsigned ACC_W   = RATE_W + 16;

  localparam logic [WGT_W-1:0]  WEIGHT_ONE = WGT_W'(65536);
  localparam logic [WGT_W-1:0]  WEIGHT_RST = WGT_W'(32768);
  localparam logic [RATE_W-1:0] RATE_MAX   = '1;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_MEAS  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD,
    ST_EWMA,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // option x qualifies when x*1.5 B/s fits under the Q32.8 estimate, i.e. x*384 <= est
  function automatic logic fits_cutoff(input logic [OPT_W-1:0] opt,
                                       input logic [RATE_W-1:0] est);
    logic [RATE_W-1:0] scaled;
    scaled = {12'b0, opt, 8'b0} + {13'b0, opt, 7'b0};
    return scaled <= est;
  endfunction

endpackage

// ----- src/abs_div.sv -----
// abs_div: restoring serial divider, one quotient bit per cycle
// depends on abs_pkg for widths
module abs_div import abs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DIVD_W-1:0]   dividend_i,
  input  logic [DUR_W-1:0]    divisor_i,
  output logic                done_o,
  output logic [RATE_W-1:0]   quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVD_W);

  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [DUR_W-1:0]  rem_q, rem_d;
  logic [DUR_W-1:0]  dsr_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DUR_W:0]    shifted;
  logic [DUR_W:0]    diff;
  logic              ge;

  assign shifted = {rem_q, quo_q[DIVD_W-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign ge      = shifted >= {1'b0, dsr_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(DIVD_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DIVD_W-2:0], ge};
      rem_d = ge ? diff[DUR_W-1:0] : shifted[DUR_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = RATE_W'(quo_q);

endmodule

// ----- src/abs_ewma.sv -----
// abs_ewma: ewma update with one shared 17x20 multiplier over four partial products
// depends on abs_pkg for widths and the unity weight
module abs_ewma import abs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [WGT_W-1:0]   weight_i,
  input  logic [RATE_W-1:0]  sample_i,
  input  logic [RATE_W-1:0]  old_i,
  output logic               done_o,
  output logic [RATE_W-1:0]  result_o
);

  localparam int unsigned HALF_W = RATE_W / 2;

  logic [WGT_W-1:0]  w_q, wc_q, w_clamp;
  logic [RATE_W-1:0] smp_q, old_q;
  logic [2:0]        step_q;
  logic              busy_q, done_q, pv_q, hi_q;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [ACC_W-1:0]  acc_q, addend;
  logic [WGT_W-1:0]  mul_a;
  logic [OPT_W-1:0]  mul_b;

  assign w_clamp = (weight_i > WEIGHT_ONE) ? WEIGHT_ONE : weight_i;

  always_comb begin
    case (step_q[1:0])
      2'd0:    begin mul_a = w_q;  mul_b = smp_q[HALF_W-1:0];      end
      2'd1:    begin mul_a = w_q;  mul_b = smp_q[RATE_W-1:HALF_W]; end
      2'd2:    begin mul_a = wc_q; mul_b = old_q[HALF_W-1:0];      end
      default: begin mul_a = wc_q; mul_b = old_q[RATE_W-1:HALF_W]; end
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign addend = hi_q ? ACC_W'({prod_q, {HALF_W{1'b0}}}) : ACC_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      pv_q   <= 1'b0;
      step_q <= '0;
    end else begin
      // last partial product lands in the accumulator on the done edge
      done_q <= busy_q && !start_i && step_q[2] && pv_q;
      if (start_i) begin
        busy_q <= 1'b1;
        pv_q   <= 1'b0;
        step_q <= '0;
      end else if (busy_q) begin
        pv_q <= ~step_q[2];
        if (!step_q[2]) begin
          step_q <= step_q + 1'b1;
        end else if (pv_q) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      w_q   <= w_clamp;
      wc_q  <= WEIGHT_ONE - w_clamp;
      smp_q <= sample_i;
      old_q <= old_i;
      acc_q <= '0;
    end else if (busy_q) begin
      prod_q <= prod_d;
      hi_q   <= step_q[0];
      if (pv_q) begin
        acc_q <= acc_q + addend;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = acc_q[ACC_W-1:16];

endmodule

// ----- src/abs_opt_mem.sv -----
// abs_opt_mem: bitrate option store, one write and one registered read port
// depends on abs_pkg for the option width
module abs_opt_mem import abs_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [OPT_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [OPT_W-1:0] rdata_o
);

  logic [OPT_W-1:0] mem [DEPTH];
  logic [OPT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/adaptive_bitrate_selector_unit.sv -----
// adaptive_bitrate_selector_unit: top level, control sequencer and result register
// depends on abs_pkg, abs_div, abs_ewma and abs_opt_mem
//
// usage:
//   input channel (in_valid_i/in_ready_o) carries op, bitrate_option, chunk_bytes and
//   duration_seconds; every input transfer yields exactly one result transfer on the
//   output channel (out_valid_o/out_ready_i), in order.
//   cfg_valid_i/cfg_ready_o writes the 17-bit ewma weight (Q1.16, reset 32768); the
//   port is always ready, writes are meant for idle periods only.
//   one item is in flight at a time: in_ready_o is high while the sequencer idles.
//   start stream, add option and unused op pass from the transfer through the emit state
//   to the result transfer. chunk measurement: serial divider (one quotient bit per cycle,
//   then done), estimate update, ewma (four partial products on one multiplier, skipped
//   when the estimate is zero, as for the first sample), table scan through the memory
//   read port, then the emit state; a zero duration skips the divider.
//   the result sits in an output register; while the receiver stalls it holds, and the
//   next item is taken and worked on, waiting only to load its own result.
//   reset clears the count, estimate and choice and sets the weight to 32768; the option
//   memory needs no clearing since only entries below the count are ever read.
module adaptive_bitrate_selector_unit import abs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  input  logic [OPT_W-1:0]    bitrate_option_i,
  input  logic [BYTES_W-1:0]  chunk_bytes_i,
  input  logic [DUR_W-1:0]    duration_seconds_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OPT_W-1:0]    selected_rate_o,
  output logic                bitrate_valid_o,
  output logic [RATE_W-1:0]   throughput_estimate_o,
  output logic                table_full_o,
  output logic                zero_duration_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [WGT_W-1:0]    cfg_data_i
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [RATE_W-1:0] est_q, est_d;
  logic [OPT_W-1:0]  chosen_q, chosen_d;
  logic              cvalid_q, cvalid_d;
  logic [OPT_W-1:0]  min_q, min_d, new_min;
  logic              full_q, full_d;
  logic              zero_q, zero_d;
  logic [RATE_W-1:0] sample_q, sample_d;
  logic [CW-1:0]     scan_q, scan_d;
  logic              pend_q, pend_d;
  logic              found_q, found_d;
  logic [OPT_W-1:0]  best_q, best_d;
  logic [WGT_W-1:0]  wgt_q;
  logic              out_valid_q, out_valid_d;
  logic [OPT_W-1:0]  out_rate_q;
  logic              out_bvalid_q, out_full_q, out_zero_q;
  logic [RATE_W-1:0] out_est_q;
  logic              out_load;

  logic              in_xfer;
  logic              div_start, div_done;
  logic [RATE_W-1:0] div_quo;
  logic              ewma_start, ewma_done;
  logic [RATE_W-1:0] ewma_res;
  logic              mem_we, mem_re;
  logic [OPT_W-1:0]  mem_rdata;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign new_min = ((count_q == '0) || (bitrate_option_i < min_q)) ? bitrate_option_i : min_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    est_d       = est_q;
    chosen_d    = chosen_q;
    cvalid_d    = cvalid_q;
    min_d       = min_q;
    full_d      = full_q;
    zero_d      = zero_q;
    sample_d    = sample_q;
    scan_d      = scan_q;
    pend_d      = 1'b0;
    found_d     = found_q;
    best_d      = best_q;
    div_start   = 1'b0;
    ewma_start  = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          full_d  = 1'b0;
          zero_d  = 1'b0;
          scan_d  = '0;
          found_d = 1'b0;
          best_d  = '0;
          state_d = ST_EMIT;
          case (op_i)
            OP_START: begin
              count_d  = '0;
              est_d    = '0;
              chosen_d = '0;
              cvalid_d = 1'b0;
            end
            OP_ADD: begin
              cvalid_d = 1'b1;
              if (count_q < DEPTH_C) begin
                mem_we   = 1'b1;
                count_d  = count_q + 1'b1;
                min_d    = new_min;
                chosen_d = new_min;
              end else begin
                full_d   = 1'b1;
                chosen_d = min_q;
              end
            end
            OP_MEAS: begin
              if (duration_seconds_i == '0) begin
                sample_d = RATE_MAX;
                zero_d   = 1'b1;
                state_d  = ST_UPD;
              end else begin
                div_start = 1'b1;
                state_d   = ST_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          sample_d = div_quo;
          state_d  = ST_UPD;
        end
      end
      ST_UPD: begin
        // a zero estimate, as for the first sample of a stream, is seeded directly from the sample
        if (est_q == '0) begin
          est_d   = sample_q;
          state_d = ST_SCAN;
        end else begin
          ewma_start = 1'b1;
          state_d    = ST_EWMA;
        end
      end
      ST_EWMA: begin
        if (ewma_done) begin
          est_d   = ewma_res;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pend_q && fits_cutoff(mem_rdata, est_q) && (!found_q || mem_rdata > best_q)) begin
          best_d  = mem_rdata;
          found_d = 1'b1;
        end
        if (scan_q < count_q) begin
          mem_re = 1'b1;
          pend_d = 1'b1;
          scan_d = scan_q + 1'b1;
        end else if (!pend_q) begin
          chosen_d = found_q ? best_q : '0;
          cvalid_d = found_q;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      est_q       <= '0;
      chosen_q    <= '0;
      cvalid_q    <= 1'b0;
      full_q      <= 1'b0;
      zero_q      <= 1'b0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      wgt_q       <= WEIGHT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      est_q       <= est_d;
      chosen_q    <= chosen_d;
      cvalid_q    <= cvalid_d;
      full_q      <= full_d;
      zero_q      <= zero_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        wgt_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    min_q    <= min_d;
    sample_q <= sample_d;
    best_q   <= best_d;
    if (out_load) begin
      out_rate_q   <= chosen_q;
      out_bvalid_q <= cvalid_q;
      out_est_q    <= est_q;
      out_full_q   <= full_q;
      out_zero_q   <= zero_q;
    end
  end

  abs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({chunk_bytes_i, {FRAC_W{1'b0}}}),
    .divisor_i  (duration_seconds_i),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  abs_ewma u_ewma (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ewma_start),
    .weight_i (wgt_q),
    .sample_i (sample_q),
    .old_i    (est_q),
    .done_o   (ewma_done),
    .result_o (ewma_res)
  );

  abs_opt_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (bitrate_option_i),
    .re_i    (mem_re),
    .raddr_i (scan_q[IW-1:0]),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o           = out_valid_q;
  assign selected_rate_o       = out_rate_q;
  assign bitrate_valid_o       = out_bvalid_q;
  assign throughput_estimate_o = out_est_q;
  assign table_full_o          = out_full_q;
  assign zero_duration_o       = out_zero_q;

endmodule

// ----- src/abs_chk.sv -----
// abs_chk: port-level assertions for the adaptive bitrate selector, bound to the top level
// depends on abs_pkg for widths and op codes
module abs_chk import abs_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [1:0]          op_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [OPT_W-1:0]    selected_rate_o,
  input logic                bitrate_valid_o,
  input logic [RATE_W-1:0]   throughput_estimate_o,
  input logic                table_full_o,
  input logic                zero_duration_o
);

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_rate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bitrate_valid_o |-> selected_rate_o == '0)
    else $error("bitrate reported without a valid choice");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(table_full_o && zero_duration_o))
    else $error("full and zero-duration flags together");

  // a stream start with a free output register reports a cleared state via the emit state
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i == OP_START && !out_valid_o |=> ##1
      out_valid_o && throughput_estimate_o == '0 && !bitrate_valid_o && !table_full_o)
    else $error("stream start did not clear the state");

endmodule

bind adaptive_bitrate_selector_unit abs_chk u_abs_chk (.*);
